FILE: rtl/kwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    localparam int VALUE_W     = 64;
    localparam int RUN_W       = 3;
    localparam int CFG_W       = 4;
    localparam int MAX_RESULTS = 32;
    localparam int KCNT_W      = 6;
    localparam int IDX_W       = 8;   // width used for index compares
    localparam int RUNS_RESET  = 8;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // item beat taken this cycle
        logic load;     // load candidate lanes from the heads
        logic reduce;   // one level of the comparator tree
        logic pop;      // take the winner into the output register
        logic emit;     // show the held result on the output channel
        logic last;
        logic done;
        logic clear;    // merge finished, clear counts, heads, closed flags and overflow
    } kwm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic can_emit;
        logic finished;
        logic slot_free;
    } kwm_status_t;

endpackage

`default_nettype wire

FILE: rtl/kwm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kwm_in_if import kwm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [RUN_W-1:0]     run;
    value_t               value;

    modport source (output valid, output mode, output run, output value, input ready);
    modport sink   (input valid, input mode, input run, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/kwm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kwm_out_if import kwm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    value_t               merged_value;
    logic [RUN_W-1:0]     source_run;
    logic                 last;
    logic                 done_res;
    logic                 overflow;

    modport source (output valid, output merged_value, output source_run, output last,
                    output done_res, output overflow, input ready);
    modport sink   (input valid, input merged_value, input source_run, input last,
                    input done_res, input overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/kwm_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kwm_cfg_if import kwm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/kwm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_ctrl import kwm_pkg::*; #(
    parameter int RED_STEPS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  kwm_status_t status,
    output kwm_cmd_t    cmd
);

    localparam int RCW = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_REDUCE = 2'd2;
    localparam logic [1:0] ST_POP    = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [KCNT_W-1:0] k_reg, k_next;
    logic [RCW-1:0]    red_reg, red_next;
    logic              more;

    assign item_ready = (state_reg == ST_IDLE);
    assign more       = status.can_emit && (k_reg < KCNT_W'(MAX_RESULTS));

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        k_next     = k_reg;
        red_next   = red_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // a popped result waits here until we know what follows it
                if (k_reg != '0)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = !more;
                    cmd.done = status.finished;
                end
                if (status.finished)
                begin
                    cmd.clear = 1'b1;
                end
                if (more)
                begin
                    cmd.load   = 1'b1;
                    red_next   = '0;
                    state_next = ST_REDUCE;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (red_reg == RCW'(RED_STEPS - 1))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    red_next = red_reg + 1'b1;
                end
            end
            ST_POP:
            begin
                if (status.slot_free)
                begin
                    cmd.pop    = 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_EVAL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            red_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            red_reg   <= red_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kwm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_datapath import kwm_pkg::*; #(
    parameter int NUM_RUNS    = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    kwm_cfg_if.sink          cfg,
    input  logic             item_mode,
    input  logic [RUN_W-1:0] item_run,
    input  value_t           item_value,
    kwm_out_if.source        results,
    input  kwm_cmd_t         cmd,
    output kwm_status_t      status
);

    localparam int RW    = $clog2(NUM_RUNS);
    localparam int LANES = 1 << RW;
    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int NW    = $clog2(NUM_RUNS + 1);
    localparam int AW    = RW + SW;
    localparam int MEM_D = 1 << AW;

    typedef struct packed {
        logic          vld;
        logic [RW-1:0] idx;
        value_t        val;
    } cand_t;

    function automatic cand_t pick(input cand_t l, input cand_t r);
        // lower index wins ties
        if (r.vld && (!l.vld || ($signed(r.val) < $signed(l.val))))
            return r;
        return l;
    endfunction

    // configuration
    logic [CFG_W-1:0] active_runs_reg;
    logic [NW-1:0]    n_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_runs_reg <= CFG_W'(RUNS_RESET);
        else if (cfg.valid)
            active_runs_reg <= cfg.data;
    end

    always_comb
    begin
        if (active_runs_reg == '0)
            n_eff = NW'(1);
        else if (IDX_W'(active_runs_reg) > IDX_W'(NUM_RUNS))
            n_eff = NW'(NUM_RUNS);
        else
            n_eff = NW'(active_runs_reg);
    end

    // queue state
    logic [CW-1:0] count_reg [NUM_RUNS];
    logic [CW-1:0] count_next[NUM_RUNS];
    logic [SW-1:0] head_reg  [NUM_RUNS];
    logic [SW-1:0] head_next [NUM_RUNS];
    logic          closed_reg [NUM_RUNS];
    logic          closed_next[NUM_RUNS];
    value_t        head_val_reg[NUM_RUNS];
    logic          overflow_reg, overflow_next;
    logic          run_on[NUM_RUNS];

    value_t        mem [MEM_D];
    value_t        rd_data_reg;
    logic          refill_pending_reg;
    logic [RW-1:0] refill_idx_reg;

    cand_t cand_reg [LANES];
    cand_t cand_next[LANES];

    // item decode
    logic [IDX_W-1:0] run_wide;
    logic             hit;
    logic [RW-1:0]    ridx;
    logic             push_ok;
    logic             queue_full;
    logic             push_wr;
    logic [SW:0]      slot_sum;
    logic [SW-1:0]    slot;
    logic [AW-1:0]    wr_addr;

    assign run_wide   = IDX_W'(item_run);
    assign hit        = run_wide < IDX_W'(n_eff);
    assign ridx       = run_wide[RW-1:0];
    assign push_ok    = cmd.accept && hit && (item_mode == MODE_PUSH) && !closed_reg[ridx];
    assign queue_full = (count_reg[ridx] == CW'(QUEUE_DEPTH));
    assign push_wr    = push_ok && !queue_full;
    assign slot_sum   = (SW + 1)'(head_reg[ridx]) + (SW + 1)'(count_reg[ridx]);
    assign slot       = (slot_sum >= (SW + 1)'(QUEUE_DEPTH))
                        ? SW'(slot_sum - (SW + 1)'(QUEUE_DEPTH)) : slot_sum[SW-1:0];
    assign wr_addr    = {ridx, slot};

    // pop of the winner
    logic [RW-1:0]    best;
    logic [SW:0]      head_inc;
    logic [SW-1:0]    head_adv;
    logic [CW-1:0]    remain;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic [IDX_W-1:0] best_wide;

    assign best      = cand_reg[0].idx;
    assign best_wide = IDX_W'(best);
    assign head_inc  = (SW + 1)'(head_reg[best]) + 1'b1;
    assign head_adv  = (head_inc == (SW + 1)'(QUEUE_DEPTH)) ? '0 : head_inc[SW-1:0];
    assign remain    = count_reg[best] - 1'b1;
    assign rd_en     = cmd.pop && (remain != '0);
    assign rd_addr   = {best, head_adv};

    always_ff @(posedge clk)
    begin
        if (push_wr)
            mem[wr_addr] <= item_value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            refill_pending_reg <= 1'b0;
        else
            refill_pending_reg <= rd_en;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            refill_idx_reg <= best;
    end

    // head value cache: one register per run, read at its own lane
    always_ff @(posedge clk)
    begin
        if (push_wr && (count_reg[ridx] == '0))
            head_val_reg[ridx] <= item_value;
        if (refill_pending_reg)
            head_val_reg[refill_idx_reg] <= rd_data_reg;
    end

    always_comb
    begin
        for (int r = 0; r < NUM_RUNS; r++)
        begin
            run_on[r]      = IDX_W'(r) < IDX_W'(n_eff);
            count_next[r]  = count_reg[r];
            head_next[r]   = head_reg[r];
            closed_next[r] = closed_reg[r];
        end
        overflow_next = overflow_reg;
        if (cmd.clear)
        begin
            for (int r = 0; r < NUM_RUNS; r++)
            begin
                count_next[r]  = '0;
                head_next[r]   = '0;
                closed_next[r] = 1'b0;
            end
            overflow_next = 1'b0;
        end
        else
        begin
            if (push_ok)
            begin
                if (queue_full)
                    overflow_next = 1'b1;
                else
                    count_next[ridx] = count_reg[ridx] + 1'b1;
            end
            else if (cmd.accept && hit && (item_mode == MODE_CLOSE))
            begin
                closed_next[ridx] = 1'b1;
            end
            if (cmd.pop)
            begin
                head_next[best]  = head_adv;
                count_next[best] = remain;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_RUNS; r++)
            begin
                count_reg[r]  <= '0;
                head_reg[r]   <= '0;
                closed_reg[r] <= 1'b0;
            end
            overflow_reg <= 1'b0;
        end
        else
        begin
            for (int r = 0; r < NUM_RUNS; r++)
            begin
                count_reg[r]  <= count_next[r];
                head_reg[r]   <= head_next[r];
                closed_reg[r] <= closed_next[r];
            end
            overflow_reg <= overflow_next;
        end
    end

    // status over the active runs
    logic any_blocked, any_data, all_done;

    always_comb
    begin
        any_blocked = 1'b0;
        any_data    = 1'b0;
        all_done    = 1'b1;
        for (int r = 0; r < NUM_RUNS; r++)
        begin
            if (run_on[r])
            begin
                if ((count_reg[r] == '0) && !closed_reg[r])
                    any_blocked = 1'b1;
                if (count_reg[r] != '0)
                    any_data = 1'b1;
                if (!closed_reg[r] || (count_reg[r] != '0))
                    all_done = 1'b0;
            end
        end
    end

    logic out_valid_reg;

    assign status.can_emit  = !any_blocked && any_data;
    assign status.finished  = all_done;
    assign status.slot_free = !out_valid_reg || results.ready;

    // comparator tree, one level per cycle, folded onto the lower lanes
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            cand_next[i] = cand_reg[i];
        if (cmd.load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                cand_next[i].idx = RW'(i);
                if (i < NUM_RUNS)
                begin
                    cand_next[i].vld = run_on[i] && (count_reg[i] != '0);
                    cand_next[i].val = (refill_pending_reg && (refill_idx_reg == RW'(i)))
                                       ? rd_data_reg : head_val_reg[i];
                end
                else
                begin
                    cand_next[i].vld = 1'b0;
                    cand_next[i].val = '0;
                end
            end
        end
        else if (cmd.reduce)
        begin
            for (int j = 0; j < LANES / 2; j++)
                cand_next[j] = pick(cand_reg[2 * j], cand_reg[2 * j + 1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
            cand_reg[i] <= cand_next[i];
    end

    // output register
    value_t           out_val_reg;
    logic [RUN_W-1:0] out_src_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;
    logic             out_done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_val_reg <= cand_reg[0].val;
            out_src_reg <= best_wide[RUN_W-1:0];
            out_ovf_reg <= overflow_reg;
        end
        if (cmd.emit)
        begin
            out_last_reg <= cmd.last;
            out_done_reg <= cmd.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    assign results.valid        = out_valid_reg;
    assign results.merged_value = out_val_reg;
    assign results.source_run   = out_src_reg;
    assign results.last         = out_last_reg;
    assign results.done_res     = out_done_reg;
    assign results.overflow     = out_ovf_reg;

`ifndef SYNTHESIS
    a_pop_winner: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> cand_reg[0].vld)
        else $error("pop without a valid winner");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg)
        else $error("result released over an unread beat");

    a_refill_once: assert property (@(posedge clk) disable iff (!rst_n)
        refill_pending_reg |=> !refill_pending_reg)
        else $error("head refill not consumed");
`endif

endmodule

`default_nettype wire

FILE: rtl/kway_sorted_run_merger.sv
`timescale 1ns / 1ps
`default_nettype none
// Each result beat passes evaluate, the folded comparator tree (one level per cycle) and pop;
//   the popped result is shown from the output register once evaluate releases it.
// An item is taken only in idle, so a new item waits until every result of the last one is released.
// A burst holds up to 32 results per item; output stalls hold the pop step.
// Reset (rst_n, async low) clears counts, heads, closed flags and overflow, sets active_runs
//   to 8; the queue memory is not cleared, there is no clearing pass.

module kway_sorted_run_merger import kwm_pkg::*; #(
    parameter int NUM_RUNS    = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    kwm_cfg_if.sink    cfg,
    kwm_in_if.sink     items,
    kwm_out_if.source  results
);

    // tree depth: one reduction step per level
    localparam int RED_STEPS = $clog2(NUM_RUNS);

    kwm_cmd_t    cmd;
    kwm_status_t status;
    logic        item_ready;

    // Controller: idle -> evaluate -> reduce x levels -> pop -> evaluate ...
    // The popped result is held unshown until evaluate knows whether another
    // beat follows (last) and whether the merge is over (done).
    kwm_ctrl #(
        .RED_STEPS (RED_STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Items are taken only in idle; the output register decouples the result side.
    assign items.ready = item_ready;

    // Datapath: per-run head cache in flops, queue bodies in one memory,
    // folded comparator tree, output register.
    kwm_datapath #(
        .NUM_RUNS    (NUM_RUNS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_mode  (items.mode),
        .item_run   (items.run),
        .item_value (items.value),
        .results    (results),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

`default_nettype wire
